### hw/rtl/dts_pkg.sv
// Package for the display temperature smoother.
// Holds field widths, register reset values, smoothing constants and the shared types.
// No dependencies.
`default_nettype none

package dts_pkg;

	// Field widths
	localparam int unsigned ADC_W      = 12;
	localparam int unsigned SCALE_W    = 16;
	localparam int unsigned TEMP_W     = 13;
	localparam int unsigned Q16_W      = 25;  // displayed value, Q16 degrees: 13-bit q4 temperature + 12 fraction bits
	localparam int unsigned FACTOR_W   = 13;
	localparam int unsigned PROD_IN_W  = ADC_W + SCALE_W;

	// Port widths
	localparam int unsigned S_TDATA_W  = 16;  // adc_sample padded to bytes
	localparam int unsigned M_TDATA_W  = 40;  // three temperatures padded to bytes
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Ring depth default
	localparam int unsigned RING_DEPTH_DEF = 8;

	// Register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd20081;
	localparam logic [TEMP_W-1:0]  MAX_TEMP_RST = 13'd7360;
	localparam logic [ADC_W-1:0]   REJECT_RST   = 12'd4000;

	// Smoothing factors in Q16
	localparam logic [FACTOR_W-1:0] FACTOR_FAR  = 13'd1311;  // 0.02
	localparam logic [FACTOR_W-1:0] FACTOR_MID  = 13'd3277;  // 0.05
	localparam logic [FACTOR_W-1:0] FACTOR_NEAR = 13'd5243;  // 0.08
	localparam logic [FACTOR_W-1:0] FACTOR_FINE = 13'd6554;  // 0.1

	// Gap thresholds in Q16 degrees
	localparam logic [Q16_W-1:0] GAP_FAR  = Q16_W'(10 * 65536);
	localparam logic [Q16_W-1:0] GAP_MID  = Q16_W'(5 * 65536);
	localparam logic [Q16_W-1:0] GAP_NEAR = Q16_W'(2 * 65536);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE    = 2'd0,
		REG_MAX_TEMP = 2'd1,
		REG_REJECT   = 2'd2
	} dts_reg_t;

	// Live configuration
	typedef struct packed {
		logic [SCALE_W-1:0] scale_q16;
		logic [TEMP_W-1:0]  max_temp_q4;
		logic [ADC_W-1:0]   reject_limit;
	} dts_cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // input beat taken: multiply, compare, ring read
		logic update;  // saturate, ring insert, smoother start
		logic divide;  // sum times reciprocal
		logic gap;     // gap magnitude and factor select
		logic step;    // smoothing step and result load
	} dts_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/dts_cfg_regs.sv
// Configuration register bank of the display temperature smoother.
// Depends on dts_pkg for widths, reset values and register indexes.
`default_nettype none

module dts_cfg_regs
	import dts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output dts_cfg_t                   cfg
);

	dts_cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_q16    <= SCALE_RST;
			cfg_q.max_temp_q4  <= MAX_TEMP_RST;
			cfg_q.reject_limit <= REJECT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCALE:    cfg_q.scale_q16    <= cfg_data[SCALE_W-1:0];
				REG_MAX_TEMP: cfg_q.max_temp_q4  <= cfg_data[TEMP_W-1:0];
				REG_REJECT:   cfg_q.reject_limit <= cfg_data[ADC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/dts_ctrl.sv
// Sequencer of the display temperature smoother.
// Walks each item through load, update, divide, gap and step; owns the output valid.
// Depends on dts_pkg for the command struct.
`default_nettype none

module dts_ctrl
	import dts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output dts_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_GAP,
		ST_STEP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Output slot can take a new result this cycle
	assign out_free = !out_valid_q || m_tready;

	// Commands decoded from state
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && s_tvalid;
		cmd.update = (state_q == ST_UPDATE);
		cmd.divide = (state_q == ST_DIVIDE);
		cmd.gap    = (state_q == ST_GAP);
		cmd.step   = (state_q == ST_STEP) && out_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_UPDATE;
				end
				ST_UPDATE: state_q <= ST_DIVIDE;
				ST_DIVIDE: state_q <= ST_GAP;
				ST_GAP:    state_q <= ST_STEP;
				ST_STEP: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/dts_datapath.sv
// Datapath of the display temperature smoother: conversion multiplier, ring memory,
// running sum, reciprocal divider and smoothing step, plus the result register.
// Depends on dts_pkg for widths, constants and the command and config structs.
`default_nettype none

module dts_datapath
	import dts_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dts_cmd_t          cmd,
	input  wire dts_cfg_t          cfg,
	input  wire logic [ADC_W-1:0]  adc_sample,
	output logic [TEMP_W-1:0]      raw_temp_q4,
	output logic [TEMP_W-1:0]      average_q4,
	output logic [TEMP_W-1:0]      shown_temp_q4,
	output logic                   sample_accepted
);

	localparam int unsigned POS_W  = $clog2(RING_DEPTH);
	localparam int unsigned SUM_W  = TEMP_W + POS_W;
	// Reciprocal for floor((sum << 12) / RING_DEPTH), exact over the whole sum range
	localparam int unsigned X_W    = SUM_W + 12;
	localparam int unsigned REC_K  = X_W + POS_W;
	localparam int unsigned M_W    = X_W + 1;
	localparam logic [63:0] REC_M_FULL =
		((64'd1 << REC_K) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
	localparam logic [M_W-1:0] REC_M = REC_M_FULL[M_W-1:0];
	localparam int unsigned REC_SH = REC_K - 12;
	localparam int unsigned AVG_W  = SUM_W + M_W;
	localparam int unsigned STEP_W = FACTOR_W + Q16_W;

	// Ring memory, no reset: an entry's read value is used only after it has been written
	logic [TEMP_W-1:0] ring_mem [RING_DEPTH];
	logic [TEMP_W-1:0] ring_rd_q;

	logic [PROD_IN_W-1:0] conv_prod_q;
	logic                 acc_q;
	logic [TEMP_W-1:0]    raw_q;
	logic [POS_W-1:0]     pos_q;
	logic                 filled_q;
	logic                 lap_q;      // first lap after fill: old entries hold fill_q
	logic [TEMP_W-1:0]    fill_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 started_q;
	logic [Q16_W-1:0]     sm_q;
	logic [AVG_W-1:0]     avg_prod_q;
	logic [Q16_W-1:0]     mag_q;
	logic                 up_q;
	logic [FACTOR_W-1:0]  factor_q;
	logic [TEMP_W-1:0]    avg4_q;

	logic [TEMP_W-1:0]    out_raw_q;
	logic [TEMP_W-1:0]    out_avg_q;
	logic [TEMP_W-1:0]    out_shown_q;
	logic                 out_acc_q;

	// Saturated conversion
	logic [PROD_IN_W-13:0] conv;
	logic [TEMP_W-1:0]     raw;
	assign conv = conv_prod_q[PROD_IN_W-1:12];
	assign raw  = (conv > (PROD_IN_W-12)'(cfg.max_temp_q4)) ? cfg.max_temp_q4
	                                                        : conv[TEMP_W-1:0];

	// Entry leaving the ring
	logic [TEMP_W-1:0] old_entry;
	assign old_entry = lap_q ? fill_q : ring_rd_q;

	// Average in Q16 and gap
	logic [Q16_W-1:0] avg16;
	logic             up;
	logic [Q16_W-1:0] mag;
	logic [FACTOR_W-1:0] factor;
	assign avg16 = avg_prod_q[REC_SH +: Q16_W];
	assign up    = (avg16 >= sm_q);
	assign mag   = up ? (avg16 - sm_q) : (sm_q - avg16);

	always_comb begin
		if (mag > GAP_FAR) begin
			factor = FACTOR_FAR;
		end else if (mag > GAP_MID) begin
			factor = FACTOR_MID;
		end else if (mag > GAP_NEAR) begin
			factor = FACTOR_NEAR;
		end else begin
			factor = FACTOR_FINE;
		end
	end

	// Smoothing step, truncated toward zero
	logic [STEP_W-1:0] step_prod;
	logic [Q16_W-1:0]  step_val;
	logic [Q16_W-1:0]  sm_next;
	assign step_prod = STEP_W'(factor_q) * STEP_W'(mag_q);
	assign step_val  = Q16_W'(step_prod >> 16);
	assign sm_next   = up_q ? (sm_q + step_val) : (sm_q - step_val);

	// Memory port and per-item payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			conv_prod_q <= PROD_IN_W'(adc_sample) * PROD_IN_W'(cfg.scale_q16);
			acc_q       <= (adc_sample <= cfg.reject_limit);
			ring_rd_q   <= ring_mem[pos_q];
		end
		if (cmd.update) begin
			raw_q <= raw;
			if (acc_q && filled_q) begin
				ring_mem[pos_q] <= raw;
			end
		end
		if (cmd.divide) begin
			avg_prod_q <= AVG_W'(sum_q) * AVG_W'(REC_M);
		end
		if (cmd.gap) begin
			mag_q    <= mag;
			up_q     <= up;
			factor_q <= factor;
			avg4_q   <= avg16[Q16_W-1:12];
		end
		if (cmd.step) begin
			out_raw_q   <= raw_q;
			out_avg_q   <= avg4_q;
			out_shown_q <= sm_next[Q16_W-1:12];
			out_acc_q   <= acc_q;
		end
	end

	// Ring state, running sum and smoother state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			filled_q  <= 1'b0;
			lap_q     <= 1'b0;
			fill_q    <= '0;
			sum_q     <= '0;
			started_q <= 1'b0;
			sm_q      <= '0;
		end else begin
			if (cmd.update) begin
				if (acc_q) begin
					if (!filled_q) begin
						// First sample fills every entry
						sum_q    <= SUM_W'(raw) * SUM_W'(RING_DEPTH);
						filled_q <= 1'b1;
						lap_q    <= 1'b1;
						fill_q   <= raw;
						pos_q    <= POS_W'(1);
					end else begin
						sum_q <= sum_q - SUM_W'(old_entry) + SUM_W'(raw);
						if (pos_q == '0) lap_q <= 1'b0;
						if (pos_q == POS_W'(RING_DEPTH - 1)) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				if (!started_q) begin
					started_q <= 1'b1;
					sm_q      <= {raw, 12'd0};
				end
			end
			if (cmd.step) begin
				sm_q <= sm_next;
			end
		end
	end

	assign raw_temp_q4     = out_raw_q;
	assign average_q4      = out_avg_q;
	assign shown_temp_q4   = out_shown_q;
	assign sample_accepted = out_acc_q;

endmodule

`default_nettype wire

### hw/rtl/display_temperature_smoother.sv
// Display temperature smoother, top level.
// Instantiates dts_cfg_regs, dts_ctrl and dts_datapath; depends on dts_pkg.
//
// Usage:
//   s_* channel takes one ADC sample per beat (tdata[11:0]).
//   m_* channel returns one result beat per sample: raw, average and shown
//   temperatures in tdata, the ring-accept flag in tuser.
//   cfg_* channel writes scale, saturation limit and reject limit; it is always
//   ready and must only be used while no sample is in flight.
// Each taken sample walks through the sequencer's conversion, ring update,
//   reciprocal divide, gap and step; m_tvalid is registered and rises when
//   the step loads the result. One sample is in flight at a time: s_tready
//   stays low until the sequencer is back in idle.
//   The ring memory read is issued in the accept cycle.
// A finished result sits in the output register; the next sample is accepted
//   meanwhile, and the sequencer holds in its last step until the slot frees.
// Reset clears the ring state, the smoother and the output valid, and reloads
//   the register defaults. No clearing pass is needed: the ring is seeded by the
//   first accepted sample.
`default_nettype none

module display_temperature_smoother
	import dts_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input samples
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] adc_sample
	// Results
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,   // [12:0] raw_temp_q4, [25:13] average_q4,
	                                              // [38:26] shown_temp_q4
	output logic                       m_tuser,   // [0] sample_accepted
	// Configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	dts_cfg_t          cfg;
	dts_cmd_t          cmd;
	logic [TEMP_W-1:0] raw_temp_q4;
	logic [TEMP_W-1:0] average_q4;
	logic [TEMP_W-1:0] shown_temp_q4;
	logic              sample_accepted;

	assign cfg_ready = 1'b1;

	dts_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	dts_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.adc_sample      (s_tdata[ADC_W-1:0]),
		.raw_temp_q4     (raw_temp_q4),
		.average_q4      (average_q4),
		.shown_temp_q4   (shown_temp_q4),
		.sample_accepted (sample_accepted)
	);

	// Result packing, first field lowest
	assign m_tdata = {1'b0, shown_temp_q4, average_q4, raw_temp_q4};
	assign m_tuser = sample_accepted;

endmodule

`default_nettype wire

### hw/rtl/dts_checker.sv
// Port-level checker for the display temperature smoother, with its bind.
// Depends on dts_pkg for port widths.
`default_nettype none

module dts_checker
	import dts_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic                 m_tuser,
	input wire logic                 cfg_ready
);

	// One sample in flight: the input stays not ready while a taken sample is processed
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken while a sample was in flight");

	// A result is on the output once its sample has walked update, divide, gap and step
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##5 m_tvalid)
		else $error("result missing after sample beat");

	// A stalled result beat holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result beat changed");

	// Configuration channel never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind display_temperature_smoother dts_checker u_dts_checker (.*);

`default_nettype wire
